FILE: rtl/ccspm_pkg.sv
// Package for the crank cadence, speed and power meter.
// Holds beat types, state and register codes, and saturation helpers.
// No dependencies; every rtl file imports it.
package ccspm_pkg;

	localparam int TIME_W = 48;
	localparam int REG_W = 32;
	localparam int RES_W = 8;
	localparam int CFG_IDX_W = 3;

	// Resistance clamp bounds, in tenths
	localparam logic [RES_W-1:0] RES_MIN = 8'd10;
	localparam logic [RES_W-1:0] RES_MAX = 8'd80;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CADENCE_CONST = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_CONST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_SLOPE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RESISTANCE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STALE_TIMEOUT = 3'd6;

	// Register reset values
	localparam logic [REG_W-1:0] CADENCE_CONST_RST = 32'd60000000;
	localparam logic [REG_W-1:0] SPEED_CONST_RST = 32'd60000000;
	localparam logic [REG_W-1:0] POWER_SLOPE_RST = 32'd65536;
	localparam logic [REG_W-1:0] POWER_OFFSET_RST = 32'd0;
	localparam logic [RES_W-1:0] RESISTANCE_RST = 8'd10;
	localparam logic [REG_W-1:0] UPDATE_PERIOD_RST = 32'd1000000;
	localparam logic [REG_W-1:0] STALE_TIMEOUT_RST = 32'd3000000;

	// Operation codes of an input beat
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Divider step counts: full span, and a 32-bit constant aligned to the top
	localparam logic [5:0] DIV_STEPS_SPAN = 6'd48;
	localparam logic [5:0] DIV_STEPS_CONST = 6'd32;

	typedef struct packed {
		logic operation;
		logic [TIME_W-1:0] time_us;
	} item_t;

	typedef struct packed {
		logic [31:0] mean_interval_us;
		logic [15:0] cadence_half_rpm;
		logic [15:0] speed_hundredths;
		logic signed [15:0] power_watts;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDGE2,
		ST_NEWEST,
		ST_OLDEST,
		ST_DIV_MEAN,
		ST_MEAN,
		ST_DIV_CAD,
		ST_CAD,
		ST_DIV_SPD,
		ST_SPD,
		ST_OUT
	} state_t;

	function automatic logic [15:0] sat16(input logic [31:0] v);
		return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic [31:0] sat32(input logic [TIME_W-1:0] v);
		return (v[TIME_W-1:32] != '0) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

FILE: rtl/crank_cadence_speed_power_meter_unit.sv
// Crank cadence, speed and power meter: top level with stamp ring and serial divider.
// Depends on ccspm_pkg for beat types, state codes and register indexes.
//
// Crank-edge timestamps are kept in a ring of the last HISTORY_DEPTH stamps held in a
// synchronous RAM with a registered read. The first edge after the ring empties also
// stores a synthetic stamp one stale timeout earlier. A tick whose time has reached the
// next update time schedules the following update, flushes the ring when the newest
// edge is older than the stale timeout, and emits one result beat: mean interval from
// oldest to newest stamp, cadence and speed as register constants divided by it, and
// power as the speed quotient times (slope * resistance + offset) in Q16.16, all
// saturated. A tick before the update time, and any edge, produce no beat. Items are
// processed one at a time; item_stall is high while one is in work. The first edge
// after the ring emptied makes two RAM writes. The shared one-bit-per-cycle restoring
// divider runs 48 steps for the span over the stamp count less one, then 32 steps
// each for cadence and speed. The result sits in an output register, so the next item
// is taken while a beat waits; a tick finishing while the previous beat is still
// stalled holds in its last state. The resistance register is clamped to
// RES_MIN..RES_MAX as it is written; writes to unknown indexes are dropped. Time
// arithmetic wraps modulo 2^48.
module crank_cadence_speed_power_meter_unit #(
	parameter int HISTORY_DEPTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	// Item channel
	input  logic item_valid,
	output logic item_stall,
	input  ccspm_pkg::item_t item,
	// Result channel
	output logic result_valid,
	input  logic result_stall,
	output ccspm_pkg::result_t result,
	// Configuration write port
	input  logic cfg_we,
	input  logic [ccspm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ccspm_pkg::REG_W-1:0] cfg_data
);
	import ccspm_pkg::*;

	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	// Fold a sum of ring index and count back into the ring
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= SUM_W'(HISTORY_DEPTH)) ? s - SUM_W'(HISTORY_DEPTH) : s;
		return r[IDX_W-1:0];
	endfunction

	// Configuration registers
	logic [REG_W-1:0] cadence_const_q;
	logic [REG_W-1:0] speed_const_q;
	logic [REG_W-1:0] power_slope_q;
	logic [REG_W-1:0] power_offset_q;
	logic [RES_W-1:0] resistance_q;
	logic [REG_W-1:0] update_period_q;
	logic [REG_W-1:0] stale_timeout_q;

	// Ring bookkeeping and scheduling
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [TIME_W-1:0] next_update_q;

	// Stamp ring RAM
	logic [TIME_W-1:0] ring [HISTORY_DEPTH];
	logic [TIME_W-1:0] rd_data_q;
	logic mem_we;
	logic [IDX_W-1:0] wr_addr;
	logic [TIME_W-1:0] wr_data;
	logic [IDX_W-1:0] rd_addr;

	// Sequencer
	state_t state_q, state_d;
	logic do_push;
	logic do_synth;
	logic do_flush;
	logic do_schedule;
	logic load_zero;
	logic out_load;

	// Working registers
	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] newest_q;
	logic [TIME_W-1:0] dvd_q;
	logic [REG_W-1:0] rem_q;
	logic [REG_W-1:0] dsr_q;
	logic [5:0] div_cnt_q;
	logic [31:0] mean_q;
	logic [15:0] cad_q;
	logic [15:0] spd_q;
	logic [40:0] gain_q;
	logic [39:0] gmag_q;
	logic neg_q;
	logic [55:0] prod_hi_q;
	logic [47:0] prod_lo_q;
	logic result_valid_q;
	result_t result_q;

	// Combinational helpers
	logic push_full;
	logic [IDX_W-1:0] push_addr;
	logic [IDX_W-1:0] head_inc;
	logic [IDX_W-1:0] newest_addr;
	logic [TIME_W-1:0] age;
	logic stale;
	logic [31:0] mean_sat;
	logic [32:0] div_trial;
	logic div_ge;
	logic [40:0] gain_d;
	logic [40:0] gain_abs;
	logic [31:0] quot32;
	logic [56:0] pwr_mag;
	logic [16:0] pwr_neg_sat;
	logic [15:0] pwr_val;
	logic [RES_W-1:0] res_clamped;

	assign push_full = (count_q == CNT_W'(HISTORY_DEPTH));
	assign push_addr = push_full ? head_q : wrap_idx(SUM_W'(head_q) + SUM_W'(count_q));
	assign head_inc = (head_q == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
	assign newest_addr = wrap_idx(SUM_W'(head_q) + SUM_W'(count_q) - SUM_W'(1));
	assign age = time_q - rd_data_q;
	assign stale = (age >= TIME_W'(stale_timeout_q));
	assign mean_sat = sat32(dvd_q);
	assign quot32 = dvd_q[31:0];

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign div_trial = {rem_q, dvd_q[TIME_W-1]};
	assign div_ge = (div_trial >= {1'b0, dsr_q});

	// Gain in Q16.16, 41-bit two's complement
	assign gain_d = {1'b0, 40'(power_slope_q) * 40'(resistance_q)}
		+ {{9{power_offset_q[31]}}, power_offset_q};
	assign gain_abs = gain_q[40] ? (41'd0 - gain_q) : gain_q;

	// Power magnitude and saturation
	assign pwr_mag = 57'(prod_hi_q) + 57'(prod_lo_q[47:16]);
	assign pwr_neg_sat = (pwr_mag > 57'd32768) ? 17'd32768 : pwr_mag[16:0];
	always_comb begin
		if (neg_q) begin
			pwr_val = 16'(17'd0 - pwr_neg_sat);
		end else begin
			pwr_val = (pwr_mag > 57'd32767) ? 16'h7FFF : pwr_mag[15:0];
		end
	end

	always_comb begin
		if (cfg_data[RES_W-1:0] < RES_MIN) begin
			res_clamped = RES_MIN;
		end else if (cfg_data[RES_W-1:0] > RES_MAX) begin
			res_clamped = RES_MAX;
		end else begin
			res_clamped = cfg_data[RES_W-1:0];
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cadence_const_q <= CADENCE_CONST_RST;
			speed_const_q <= SPEED_CONST_RST;
			power_slope_q <= POWER_SLOPE_RST;
			power_offset_q <= POWER_OFFSET_RST;
			resistance_q <= RESISTANCE_RST;
			update_period_q <= UPDATE_PERIOD_RST;
			stale_timeout_q <= STALE_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CADENCE_CONST: cadence_const_q <= cfg_data;
				REG_SPEED_CONST: speed_const_q <= cfg_data;
				REG_POWER_SLOPE: power_slope_q <= cfg_data;
				REG_POWER_OFFSET: power_offset_q <= cfg_data;
				REG_RESISTANCE: resistance_q <= res_clamped;
				REG_UPDATE_PERIOD: update_period_q <= cfg_data;
				REG_STALE_TIMEOUT: stale_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stamp ring: one write and one registered read a cycle. The sequencer never uses
	// data read from an entry in its write cycle, so no forwarding path is needed.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring[wr_addr] <= wr_data;
		end
		rd_data_q <= ring[rd_addr];
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, RAM control and datapath strobes
	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		wr_addr = push_addr;
		wr_data = item.time_us;
		rd_addr = head_q;
		do_push = 1'b0;
		do_synth = 1'b0;
		do_flush = 1'b0;
		do_schedule = 1'b0;
		load_zero = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (item.operation == OP_EDGE) begin
						mem_we = 1'b1;
						if (count_q == '0) begin
							// Seed the ring with a stamp one timeout back
							wr_addr = head_q;
							wr_data = item.time_us - TIME_W'(stale_timeout_q);
							do_synth = 1'b1;
							state_d = ST_EDGE2;
						end else begin
							do_push = 1'b1;
						end
					end else if (item.time_us >= next_update_q) begin
						do_schedule = 1'b1;
						if (count_q == '0) begin
							load_zero = 1'b1;
							state_d = ST_OUT;
						end else begin
							rd_addr = newest_addr;
							state_d = ST_NEWEST;
						end
					end
				end
			end
			ST_EDGE2: begin
				mem_we = 1'b1;
				wr_data = time_q;
				do_push = 1'b1;
				state_d = ST_IDLE;
			end
			ST_NEWEST: begin
				if (stale) begin
					do_flush = 1'b1;
					load_zero = 1'b1;
					state_d = ST_OUT;
				end else if (count_q < CNT_W'(2)) begin
					load_zero = 1'b1;
					state_d = ST_OUT;
				end else begin
					rd_addr = head_q;
					state_d = ST_OLDEST;
				end
			end
			ST_OLDEST: state_d = ST_DIV_MEAN;
			ST_DIV_MEAN: begin
				if (div_cnt_q == 6'd1) begin
					state_d = ST_MEAN;
				end
			end
			ST_MEAN: begin
				if (mean_sat == '0) begin
					load_zero = 1'b1;
					state_d = ST_OUT;
				end else begin
					state_d = ST_DIV_CAD;
				end
			end
			ST_DIV_CAD: begin
				if (div_cnt_q == 6'd1) begin
					state_d = ST_CAD;
				end
			end
			ST_CAD: state_d = ST_DIV_SPD;
			ST_DIV_SPD: begin
				if (div_cnt_q == 6'd1) begin
					state_d = ST_SPD;
				end
			end
			ST_SPD: state_d = ST_OUT;
			ST_OUT: begin
				// Hold until the output register is free
				if (!result_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Ring bookkeeping, scheduling and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			next_update_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (do_synth) begin
				count_q <= CNT_W'(1);
			end else if (do_push) begin
				if (push_full) begin
					head_q <= head_inc;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (do_flush) begin
				head_q <= '0;
				count_q <= '0;
			end
			if (do_schedule) begin
				next_update_q <= item.time_us + TIME_W'(update_period_q);
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: divider, quotient capture, power products
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			time_q <= item.time_us;
		end
		case (state_q)
			ST_NEWEST: newest_q <= rd_data_q;
			ST_OLDEST: begin
				dvd_q <= newest_q - rd_data_q;
				rem_q <= '0;
				dsr_q <= REG_W'(count_q) - REG_W'(1);
				div_cnt_q <= DIV_STEPS_SPAN;
			end
			ST_DIV_MEAN, ST_DIV_CAD, ST_DIV_SPD: begin
				rem_q <= div_ge ? REG_W'(div_trial - {1'b0, dsr_q}) : div_trial[REG_W-1:0];
				dvd_q <= {dvd_q[TIME_W-2:0], div_ge};
				div_cnt_q <= div_cnt_q - 6'd1;
			end
			ST_MEAN: begin
				// A zero mean is cleared below instead
				if (mean_sat != '0) begin
					mean_q <= mean_sat;
					gain_q <= gain_d;
					dvd_q <= {cadence_const_q, 16'd0};
					rem_q <= '0;
					dsr_q <= mean_sat;
					div_cnt_q <= DIV_STEPS_CONST;
				end
			end
			ST_CAD: begin
				cad_q <= sat16(quot32);
				neg_q <= gain_q[40];
				gmag_q <= gain_abs[39:0];
				dvd_q <= {speed_const_q, 16'd0};
				rem_q <= '0;
				div_cnt_q <= DIV_STEPS_CONST;
			end
			ST_SPD: begin
				spd_q <= sat16(quot32);
				prod_hi_q <= quot32 * gmag_q[39:16];
				prod_lo_q <= quot32 * gmag_q[15:0];
			end
			default: ;
		endcase
		// Zero interval: clear every field, power included
		if (load_zero) begin
			mean_q <= '0;
			cad_q <= '0;
			spd_q <= '0;
			neg_q <= 1'b0;
			prod_hi_q <= '0;
			prod_lo_q <= '0;
		end
		if (out_load) begin
			result_q.mean_interval_us <= mean_q;
			result_q.cadence_half_rpm <= cad_q;
			result_q.speed_hundredths <= spd_q;
			result_q.power_watts <= pwr_val;
		end
	end

	assign item_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

FILE: rtl/ccspm_checker.sv
// Port-level checks for the crank cadence, speed and power meter, with its bind.
// Depends on ccspm_pkg and on the top level crank_cadence_speed_power_meter_unit.
module ccspm_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input ccspm_pkg::item_t item,
	input logic result_valid,
	input logic result_stall,
	input ccspm_pkg::result_t result
);
	import ccspm_pkg::*;

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result payload changed while stalled");

	a_zero_interval: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.mean_interval_us == 32'd0 |->
			result.cadence_half_rpm == 16'd0 && result.speed_hundredths == 16'd0
			&& result.power_watts == 16'sd0)
		else $error("non-zero cadence, speed or power with zero interval");

	a_edge_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.operation == OP_EDGE |=> !$rose(result_valid))
		else $error("crank edge produced a result beat");

endmodule

bind crank_cadence_speed_power_meter_unit ccspm_checker u_ccspm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item_valid),
	.item_stall(item_stall),
	.item(item),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result(result)
);

FILE: tb/tb_top.sv
// Testbench for the crank cadence, speed and power meter unit.
// Drives edge and tick beats, predicts every reading and checks each result beat.
// Depends on ccspm_pkg and crank_cadence_speed_power_meter_unit only.
`timescale 1ns / 100ps

module tb_top;
	import ccspm_pkg::*;

	// Margin after the last beat, longer than the worst full update
	localparam int SETTLE_CYCLES = 130;
	// Long receiver hold-off, enough for the block to back up into its input
	localparam int CHOKE_CYCLES = 3000;
	// Index with no register behind it; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER [8] = '{REG_CADENCE_CONST, REG_SPEED_CONST,
		REG_POWER_SLOPE, REG_POWER_OFFSET, REG_RESISTANCE, REG_UPDATE_PERIOD,
		REG_STALE_TIMEOUT, REG_UNUSED};

	// Holds a private copy of the meter: registers, stamp ring and update schedule.
	// Every accepted beat advances it; readings it produces wait here in order.
	class meter_scoreboard;
		localparam int RING_DEPTH = 8;
		localparam int PRINT_LIMIT = 40;

		logic [31:0] cadence_k, speed_k, slope_q16, period_us, timeout_us;
		logic signed [31:0] offset_q16;
		logic [7:0] res_tenths;
		logic [47:0] stamps [RING_DEPTH];
		int head, fill;
		logic [47:0] next_update;
		result_t expected_readings [$];
		int mismatches;

		function new();
			cadence_k = CADENCE_CONST_RST;
			speed_k = SPEED_CONST_RST;
			slope_q16 = POWER_SLOPE_RST;
			offset_q16 = POWER_OFFSET_RST;
			res_tenths = RESISTANCE_RST;
			period_us = UPDATE_PERIOD_RST;
			timeout_us = STALE_TIMEOUT_RST;
			foreach (stamps[i]) stamps[i] = '0;
			head = 0;
			fill = 0;
			next_update = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			logic [7:0] r8;
			case (idx)
				REG_CADENCE_CONST: cadence_k = data;
				REG_SPEED_CONST: speed_k = data;
				REG_POWER_SLOPE: slope_q16 = data;
				REG_POWER_OFFSET: offset_q16 = data;
				REG_RESISTANCE: begin
					r8 = data[7:0];
					if (r8 < RES_MIN)
						r8 = RES_MIN;
					else if (r8 > RES_MAX)
						r8 = RES_MAX;
					res_tenths = r8;
				end
				REG_UPDATE_PERIOD: period_us = data;
				REG_STALE_TIMEOUT: timeout_us = data;
				default: ;
			endcase
		endfunction

		function void push_stamp(logic [47:0] t);
			if (fill < RING_DEPTH) begin
				stamps[(head + fill) % RING_DEPTH] = t;
				fill++;
			end else begin
				stamps[head] = t;
				head = (head + 1) % RING_DEPTH;
			end
		endfunction

		function logic [47:0] newest_stamp();
			return stamps[(head + fill - 1) % RING_DEPTH];
		endfunction

		function logic [15:0] clip16(logic [63:0] v);
			return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
		endfunction

		// Speed quotient times the Q16.16 gain, magnitude taken apart so it stays in 64 bits
		function logic [15:0] power_from(logic [63:0] q);
			longint gain;
			logic [63:0] g, mag;
			gain = longint'(slope_q16) * longint'(res_tenths) + longint'(offset_q16);
			g = (gain < 0) ? 64'(-gain) : 64'(gain);
			mag = q * (g >> 16) + ((q * (g & 64'hFFFF)) >> 16);
			if (gain < 0) begin
				if (mag > 64'd32768)
					mag = 64'd32768;
				return 16'(64'd0 - mag);
			end
			return (mag > 64'd32767) ? 16'd32767 : mag[15:0];
		endfunction

		function void note_item(item_t beat);
			logic [47:0] t, span;
			logic [63:0] mean, q;
			result_t r;
			t = beat.time_us;
			if (beat.operation == OP_EDGE) begin
				if (fill == 0)
					push_stamp(t - 48'(timeout_us));
				push_stamp(t);
				return;
			end
			if (t < next_update)
				return;
			next_update = t + 48'(period_us);
			if (fill > 0 && (t - newest_stamp()) >= 48'(timeout_us)) begin
				fill = 0;
				head = 0;
			end
			mean = '0;
			if (fill >= 2) begin
				span = newest_stamp() - stamps[head];
				mean = {16'd0, span} / 64'(fill - 1);
				if (mean > 64'hFFFF_FFFF)
					mean = 64'hFFFF_FFFF;
			end
			r = '0;
			r.mean_interval_us = mean[31:0];
			if (mean != 0) begin
				q = {32'd0, speed_k} / mean;
				r.cadence_half_rpm = clip16({32'd0, cadence_k} / mean);
				r.speed_hundredths = clip16(q);
				r.power_watts = power_from(q);
			end
			expected_readings.push_back(r);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= PRINT_LIMIT)
				$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_readings.size() == 0) begin
				report_mismatch($sformatf("result beat with none expected: %h", got));
				return;
			end
			want = expected_readings.pop_front();
			if (got.mean_interval_us !== want.mean_interval_us)
				report_mismatch($sformatf("mean_interval_us %0d, want %0d",
					got.mean_interval_us, want.mean_interval_us));
			if (got.cadence_half_rpm !== want.cadence_half_rpm)
				report_mismatch($sformatf("cadence_half_rpm %0d, want %0d",
					got.cadence_half_rpm, want.cadence_half_rpm));
			if (got.speed_hundredths !== want.speed_hundredths)
				report_mismatch($sformatf("speed_hundredths %0d, want %0d",
					got.speed_hundredths, want.speed_hundredths));
			if (got.power_watts !== want.power_watts)
				report_mismatch($sformatf("power_watts %0d, want %0d",
					got.power_watts, want.power_watts));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0] cfg_data;

	meter_scoreboard sb;
	logic [47:0] now_us;     // running time base of the well-formed beats
	bit quiet_mode;          // no idling on either side while set
	int choke_cycles;        // receiver picks this up and holds off for that long

	crank_cadence_speed_power_meter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitors: sample on the edge, before any of this edge's updates land
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			sb.note_item(item);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	// Offer one beat after a random gap, and hold it until the block takes it.
	// Valid stays high into the next beat when no gap is drawn.
	task automatic send_beat(input logic op, input logic [47:0] t);
		int gap;
		gap = quiet_mode ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{operation: op, time_us: t};
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	// Drop valid, wait for every reading to come back, then let any
	// reading-less beat still in work finish before touching registers.
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (sb.expected_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all seven registers back to back, then a stray write to the unused index
	task automatic program_meter(input logic [31:0] cad, spd, slope, off, res, period,
		timeout);
		logic [31:0] vals [8];
		vals = '{cad, spd, slope, off, res, period, timeout, $urandom};
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_data <= vals[i];
			sb.write_reg(REG_ORDER[i], vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Mostly a forward-moving stream of edges and ticks paced to the current
	// period and timeout; the rest is noise and edges that step back in time.
	task automatic run_random(input int n);
		int unsigned pace;
		int pick;
		logic op;
		logic [47:0] t;
		pace = (sb.period_us < sb.timeout_us) ? sb.period_us : sb.timeout_us;
		if (pace < 16)
			pace = 16;
		if (pace > 32'h4000_0000)
			pace = 32'h4000_0000;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				// Noise: any operation at any time; follow a tick so the schedule recovers
				op = 1'($urandom_range(0, 1));
				t = 48'({$urandom, $urandom});
				if (op == OP_TICK)
					now_us = t;
			end else if (pick < 15) begin
				// Out-of-order edge
				op = OP_EDGE;
				t = now_us - 48'($urandom_range(1, pace));
			end else begin
				if ($urandom_range(0, 9) == 0)
					now_us += 48'(pace) * 48'($urandom_range(2, 6));
				else
					now_us += 48'($urandom_range(1, pace));
				op = ($urandom_range(0, 4) < 3) ? OP_EDGE : OP_TICK;
				t = now_us;
			end
			send_beat(op, t);
		end
	endtask

	// Receiver: random hold-off before each beat, plus one long choke on request
	initial begin : result_sink
		int hold;
		result_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (choke_cycles > 0) begin
				result_stall <= 1'b1;
				repeat (choke_cycles) @(posedge clk);
				choke_cycles = 0;
			end
			hold = quiet_mode ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	initial begin
		sb = new();
		item_valid <= 1'b0;
		item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		now_us = 48'd2_000_000;
		quiet_mode = 1'b0;
		choke_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats on the reset register values.
		// Tick on an empty ring: reading of all zeros.
		send_beat(OP_TICK, 48'd0);
		// First edge: the synthetic stamp one timeout back wraps below zero
		send_beat(OP_EDGE, 48'd5);
		send_beat(OP_TICK, 48'd1_000_000);
		// Tick before the next update time: no reading
		send_beat(OP_TICK, 48'd1_000_001);
		// More edges than the ring holds overflow it and push out the oldest stamps
		for (int k = 0; k < 9; k++)
			send_beat(OP_EDGE, 48'd1_100_000 + 48'(k) * 48'd250_000);
		send_beat(OP_TICK, 48'd3_100_000);
		// Newest edge older than the timeout: history flushed
		send_beat(OP_TICK, 48'd6_100_001);
		// Span of one over two intervals: zero mean, so zero outputs
		send_beat(OP_EDGE, 48'd7_100_001);
		send_beat(OP_EDGE, 48'd4_100_002);
		send_beat(OP_TICK, 48'd7_100_001);
		// Huge span: mean saturates at 32 bits
		send_beat(OP_EDGE, 48'h0100_0000_0000);
		send_beat(OP_TICK, 48'h0100_0000_000A);
		// Top of the time range, then a tick after the update time wraps round
		send_beat(OP_EDGE, 48'hFFFF_FFFF_FFFF);
		send_beat(OP_TICK, 48'hFFFF_FFFF_FFFF);
		send_beat(OP_TICK, 48'd999_999);
		wait_idle();

		// Typical settings, short period and timeout
		program_meter(32'd60_000_000, 32'd60_000_000, 32'd65536, 32'd0, 32'd10, 32'd1000,
			32'd5000);
		run_random(120);
		wait_idle();

		// Everything at the top: saturated outputs, update on every in-order tick,
		// resistance clamped down to its maximum
		quiet_mode = 1'b1;
		program_meter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd255,
			32'd0, 32'hFFFF_FFFF);
		run_random(60);
		wait_idle();

		// Everything at the bottom: zero timeout flushes on every update,
		// resistance clamped up to its minimum
		quiet_mode = 1'b0;
		program_meter(32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'd0);
		run_random(30);
		wait_idle();

		// Most negative offset with a large speed: power saturates low
		program_meter($urandom, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'd45, 32'd500,
			32'd20000);
		run_random(60);
		wait_idle();

		// Long hold-off on the result side while beats keep coming:
		// the output register fills and the block must stall its input
		choke_cycles = CHOKE_CYCLES;
		program_meter(32'd60_000_000, 32'd6_000_000, $urandom_range(0, 32'h0040_0000),
			$urandom, $urandom, 32'd0, 32'd50000);
		run_random(80);
		wait_idle();

		// Random settings, with the odd phase free of idling
		for (int ph = 0; ph < 5; ph++) begin
			quiet_mode = ($urandom_range(0, 3) == 0);
			program_meter($urandom >> $urandom_range(0, 31), $urandom >> $urandom_range(0, 31),
				$urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0010_0000),
				$urandom, $urandom, $urandom_range(0, 4000),
				($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 20000));
			run_random(80);
			wait_idle();
		end

		if (sb.mismatches == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	// Hard stop well past the slowest correct run
	initial begin
		#8_000_000;
		$display("tb_top failed");
		$finish;
	end

endmodule
